// ===== hdl/timestamp_sorted_bounded_cache_top_defines.svh =====
// Assertion macros for the timestamp-sorted cache.
// Taken in by every file that carries concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TIMESTAMP_SORTED_BOUNDED_CACHE_TOP_DEFINES_SVH
`define TIMESTAMP_SORTED_BOUNDED_CACHE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define TSBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tsbc check failed");

// Checked on every clock edge, reset included.
`define TSBC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tsbc check failed");

`else

`define TSBC_ASSERT(lbl, prop)
`define TSBC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hdl/tsbc_pkg.sv =====
// Types and constants of the timestamp-sorted cache.
// No dependencies; used by the channel interfaces, the cell and the top level.
package tsbc_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(60);
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

  // configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_REPLACE = 1'b1;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_READ_OK = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] time_stamp;
    logic [WORD_W-1:0] force_x;
    logic [WORD_W-1:0] force_y;
    logic [WORD_W-1:0] step_time;
    logic [WORD_W-1:0] velocity_x;
    logic [WORD_W-1:0] velocity_y;
  } entry_t;

  typedef struct packed {
    logic req_type;
    logic [WORD_W-1:0] time_stamp;
    logic [WORD_W-1:0] force_x;
    logic [WORD_W-1:0] force_y;
    logic [WORD_W-1:0] step_time;
    logic [WORD_W-1:0] velocity_x;
    logic [WORD_W-1:0] velocity_y;
    logic [5:0] read_index;
  } req_t;

  typedef struct packed {
    status_e status;
    logic evicted_oldest;
    logic [5:0] slot;
    logic [6:0] entry_count;
    logic [WORD_W-1:0] out_time_stamp;
    logic [WORD_W-1:0] out_force_x;
    logic [WORD_W-1:0] out_force_y;
    logic [WORD_W-1:0] out_step_time;
    logic [WORD_W-1:0] out_velocity_x;
    logic [WORD_W-1:0] out_velocity_y;
  } rsp_t;

  // broadcast from the control to every cell during an update
  typedef struct packed {
    logic evict;
    logic replace;
  } cell_ctrl_t;

endpackage

// ===== hdl/tsbc_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on tsbc_pkg.
interface tsbc_req_if;
  import tsbc_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsbc_rsp_if;
  import tsbc_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/timestamp_sorted_bounded_cache_top.sv =====
// Top level of the timestamp-sorted cache: control, row of cells, result register.
// Depends on tsbc_pkg, tsbc_if.sv, tsbc_cell and the assertion macro header.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  req_i    | in  | valid/ready        | req_type, time_stamp, five words, read_index
//  rsp_o    | out | valid/ready        | status, evicted_oldest, slot, count, six words
//  cfg      | in  | cfg_we_i, no ready | cfg_idx_i selects register, cfg_data_i
//
// Each item passes through accept, a compare in every cell, then the shift/write update.
// The update waits while the result register still holds an untaken result.
// Reset empties the cache (count zero) and sets capacity 60, replace on; entry
// contents stay as they are and need no clearing pass.
`include "timestamp_sorted_bounded_cache_top_defines.svh"

module timestamp_sorted_bounded_cache_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tsbc_pkg::CFG_W-1:0]    cfg_data_i,
  tsbc_req_if.sink                      req_i,
  tsbc_rsp_if.source                    rsp_o
);
  import tsbc_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q;
  rsp_t             rsp_q, rsp_d;
  logic             out_valid_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cap_q, cap_eff;
  logic             replace_on_q;

  entry_t           entry_w [DEPTH];
  entry_t           new_w;
  logic [DEPTH-1:0] a_w, eq_w, hit_w, rep_w, valid_w;
  cell_ctrl_t       ctrl_w;
  logic             full_w, drop_w, evict_w, replace_w, write_w, is_ins_w;
  logic             upd_fire, out_free;
  logic [IDX_W-1:0] slot_w;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      replace_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: cap_q <= cfg_data_i[CNT_W-1:0];
        CFG_REPLACE:  replace_on_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
  end

  assign new_w = '{time_stamp: req_q.time_stamp, force_x: req_q.force_x,
                   force_y: req_q.force_y, step_time: req_q.step_time,
                   velocity_x: req_q.velocity_x, velocity_y: req_q.velocity_y};

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lft, rgt;
    logic   a_l, a_r, eq_r;

    assign valid_w[i] = (CNT_W'(i) < fill_q);

    if (i == 0) begin : g_first
      assign lft = new_w;
      assign a_l = 1'b1;
    end else begin : g_mid
      assign lft = entry_w[i-1];
      assign a_l = a_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rgt = '0;
      assign a_r = 1'b0;
      assign eq_r = 1'b0;
    end else begin : g_inner
      assign rgt = entry_w[i+1];
      assign a_r = a_w[i+1];
      assign eq_r = eq_w[i+1];
    end

    tsbc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (state_q == S_CMP),
      .upd_en_i   (upd_fire && write_w),
      .ctrl_i     (ctrl_w),
      .first_i    (i == 0),
      .valid_i    (valid_w[i]),
      .new_i      (new_w),
      .left_i     (lft),
      .right_i    (rgt),
      .a_left_i   (a_l),
      .a_right_i  (a_r),
      .eq_right_i (eq_r),
      .entry_o    (entry_w[i]),
      .a_o        (a_w[i]),
      .eq_o       (eq_w[i]),
      .hit_o      (hit_w[i]),
      .rep_o      (rep_w[i])
    );
  end

  // insert decision; a full cache holds at least one entry, so cell 0 is valid
  always_comb begin
    is_ins_w = (req_q.req_type == REQ_INSERT);
    full_w = (fill_q >= cap_eff);
    drop_w = is_ins_w && full_w && !a_w[0] && !eq_w[0];
    evict_w = is_ins_w && full_w && !drop_w;
    replace_w = replace_on_q && (|rep_w);
    write_w = is_ins_w && !drop_w;
    ctrl_w = '{evict: evict_w, replace: replace_w};
  end

  always_comb begin
    slot_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_w[i]) begin
        slot_w = slot_w | IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    fill_d = fill_q;
    if (!is_ins_w) begin
      rsp_d.slot = req_q.read_index;
      if (CNT_W'(req_q.read_index) < fill_q) begin
        rsp_d.status = ST_READ_OK;
        rsp_d.out_time_stamp = entry_w[req_q.read_index].time_stamp;
        rsp_d.out_force_x = entry_w[req_q.read_index].force_x;
        rsp_d.out_force_y = entry_w[req_q.read_index].force_y;
        rsp_d.out_step_time = entry_w[req_q.read_index].step_time;
        rsp_d.out_velocity_x = entry_w[req_q.read_index].velocity_x;
        rsp_d.out_velocity_y = entry_w[req_q.read_index].velocity_y;
      end else begin
        rsp_d.status = ST_READ_EMPTY;
      end
    end else if (drop_w) begin
      rsp_d.status = ST_DROPPED;
    end else begin
      fill_d = fill_q - CNT_W'(evict_w) + CNT_W'(!replace_w);
      rsp_d.status = replace_w ? ST_REPLACED : ST_INSERTED;
      rsp_d.evicted_oldest = evict_w;
      rsp_d.slot = 6'(slot_w);
    end
    rsp_d.entry_count = 7'(fill_d);
  end

  assign out_free = !out_valid_q || rsp_o.ready;
  assign upd_fire = (state_q == S_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_i.valid) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_fire) begin
        fill_q <= fill_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data = rsp_q;

  // exactly one cell takes the new item
  `TSBC_ASSERT(a_hit_onehot, (state_q == S_UPD && write_w) |-> $onehot(hit_w))
  // reads and dropped inserts leave the count alone
  `TSBC_ASSERT(a_count_kept, (upd_fire && !write_w) |=> (fill_q == $past(fill_q)))
  // a plain insert grows the cache
  `TSBC_ASSERT(a_count_grows, (upd_fire && write_w && !evict_w && !replace_w) |=> (fill_q > $past(fill_q)))
  // replace after eviction shrinks it
  `TSBC_ASSERT(a_count_shrinks, (upd_fire && evict_w && replace_w) |=> (fill_q < $past(fill_q)))

endmodule

// ===== hdl/tsbc_cell.sv =====
// One slot of the sorted row: holds an entry, compares it with the key and
// shifts from either neighbour. Depends on tsbc_pkg.
module tsbc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmp_en_i,
  input  logic                upd_en_i,
  input  tsbc_pkg::cell_ctrl_t ctrl_i,
  input  logic                first_i,
  input  logic                valid_i,
  input  tsbc_pkg::entry_t    new_i,
  input  tsbc_pkg::entry_t    left_i,
  input  tsbc_pkg::entry_t    right_i,
  input  logic                a_left_i,
  input  logic                a_right_i,
  input  logic                eq_right_i,
  output tsbc_pkg::entry_t    entry_o,
  output logic                a_o,
  output logic                eq_o,
  output logic                hit_o,
  output logic                rep_o
);
  import tsbc_pkg::*;

  entry_t entry_q, entry_d;
  logic   a_q, eq_q;
  logic   b_here, b_prev;

  // a: valid and older than the key; eq: valid and equal to it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmp_en_i) begin
      a_q <= valid_i && (entry_q.time_stamp < new_i.time_stamp);
      eq_q <= valid_i && (entry_q.time_stamp == new_i.time_stamp);
    end
  end

  // after an eviction every position refers to the entry one to the right
  always_comb begin
    b_here = ctrl_i.evict ? a_right_i : a_q;
    b_prev = first_i || (ctrl_i.evict ? a_q : a_left_i);
    hit_o = !b_here && b_prev;
    rep_o = hit_o && (ctrl_i.evict ? eq_right_i : eq_q);
  end

  always_comb begin
    entry_d = entry_q;
    if (hit_o) begin
      entry_d = new_i;
    end else if (!ctrl_i.evict) begin
      if (!ctrl_i.replace && !b_here) begin
        entry_d = left_i;
      end
    end else begin
      if (ctrl_i.replace || b_here) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign a_o = a_q;
  assign eq_o = eq_q;

endmodule
